// ----- src/mhs_pkg.sv -----
package mhs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 20;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NOMINAL_AIR_TEMP     = 3'd0,
      CSR_NOMINAL_PROCESS_TEMP = 3'd1,
      CSR_NOMINAL_SPEED        = 3'd2,
      CSR_NOMINAL_TORQUE       = 3'd3,
      CSR_CRITICAL_LEVEL       = 3'd4,
      CSR_WARNING_LEVEL        = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_HEALTHY  = 2'd0,
      STATUS_WARNING  = 2'd1,
      STATUS_CRITICAL = 2'd2
   } health_status_type;

   localparam logic [12:0] RESET_NOMINAL_AIR_TEMP     = 13'd2980;
   localparam logic [12:0] RESET_NOMINAL_PROCESS_TEMP = 13'd3090;
   localparam logic [12:0] RESET_NOMINAL_SPEED        = 13'd1500;
   localparam logic [10:0] RESET_NOMINAL_TORQUE       = 11'd400;
   localparam logic [19:0] RESET_CRITICAL_LEVEL       = 20'd400000;
   localparam logic [19:0] RESET_WARNING_LEVEL        = 20'd700000;

   localparam logic [13:0] FULL_SCORE = 14'd10000;

endpackage

// ----- src/machine_health_score.sv -----
// Machine health scorer. Each transfer on the req_ channel carries one telemetry
// sample; one rsp_ transfer returns its temperature, speed, torque and wear
// scores (hundredths of a point), the weighted composite
// 35*wear + 25*temp + 25*torque + 15*speed (ten-thousandths) and a status of
// healthy, warning or critical against the two csr_ levels. The block is a
// two-register pipeline: samples are captured in an input register, scored by
// constant multiplies and compares, and held in a result register. It takes
// one sample per cycle while rsp_stall is low; rsp_stall backs up through
// req_stall. Write the csr_ registers only while no sample is in flight.
module machine_health_score (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [12:0]                          req_air_temp,
   input  logic [12:0]                          req_process_temp,
   input  logic [12:0]                          req_spindle_speed,
   input  logic [10:0]                          req_torque_sample,
   input  logic [9:0]                           req_tool_wear,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [13:0]                          rsp_temp_score,
   output logic signed [14:0]                   rsp_speed_score,
   output logic signed [14:0]                   rsp_torque_score,
   output logic signed [14:0]                   rsp_wear_score,
   output logic signed [20:0]                   rsp_health_score,
   output logic [1:0]                           rsp_health_status,
   input  logic                                 csr_write_enable,
   input  logic [mhs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mhs_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   // configuration
   logic [12:0] nom_air_ff;
   logic [12:0] nom_proc_ff;
   logic [12:0] nom_speed_ff;
   logic [10:0] nom_torque_ff;
   logic [19:0] crit_level_ff;
   logic [19:0] warn_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nom_air_ff    <= mhs_pkg::RESET_NOMINAL_AIR_TEMP;
         nom_proc_ff   <= mhs_pkg::RESET_NOMINAL_PROCESS_TEMP;
         nom_speed_ff  <= mhs_pkg::RESET_NOMINAL_SPEED;
         nom_torque_ff <= mhs_pkg::RESET_NOMINAL_TORQUE;
         crit_level_ff <= mhs_pkg::RESET_CRITICAL_LEVEL;
         warn_level_ff <= mhs_pkg::RESET_WARNING_LEVEL;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mhs_pkg::CSR_NOMINAL_AIR_TEMP:     nom_air_ff    <= csr_data[12:0];
            mhs_pkg::CSR_NOMINAL_PROCESS_TEMP: nom_proc_ff   <= csr_data[12:0];
            mhs_pkg::CSR_NOMINAL_SPEED:        nom_speed_ff  <= csr_data[12:0];
            mhs_pkg::CSR_NOMINAL_TORQUE:       nom_torque_ff <= csr_data[10:0];
            mhs_pkg::CSR_CRITICAL_LEVEL:       crit_level_ff <= csr_data[19:0];
            mhs_pkg::CSR_WARNING_LEVEL:        warn_level_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic in_valid_ff;
   logic out_valid_ff;
   logic out_load;
   logic in_load;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // input register
   logic [12:0] air_ff;
   logic [12:0] proc_ff;
   logic [12:0] speed_ff;
   logic [10:0] torque_ff;
   logic [9:0]  wear_ff;

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         air_ff    <= req_air_temp;
         proc_ff   <= req_process_temp;
         speed_ff  <= req_spindle_speed;
         torque_ff <= req_torque_sample;
         wear_ff   <= req_tool_wear;
      end
   end

   // scoring
   logic [12:0]        air_dev;
   logic [12:0]        proc_dev;
   logic [12:0]        speed_dev;
   logic [10:0]        torque_dev;
   logic [18:0]        temp_penalty;
   logic [13:0]        temp_in;
   logic signed [17:0] speed_dev_s;
   logic signed [17:0] torque_dev_s;
   logic signed [17:0] torque_s;
   logic signed [17:0] wear_s;
   logic signed [17:0] speed_wide;
   logic signed [17:0] torque_wide;
   logic signed [17:0] wear_wide;
   logic signed [14:0] speed_in;
   logic signed [14:0] torque_in;
   logic signed [14:0] wear_in;
   logic signed [21:0] total_wide;
   logic signed [20:0] total_in;
   mhs_pkg::health_status_type status_in;

   always_comb begin
      air_dev    = (air_ff >= nom_air_ff) ? air_ff - nom_air_ff : nom_air_ff - air_ff;
      proc_dev   = (proc_ff >= nom_proc_ff) ? proc_ff - nom_proc_ff : nom_proc_ff - proc_ff;
      speed_dev  = (speed_ff >= nom_speed_ff) ? speed_ff - nom_speed_ff
                                              : nom_speed_ff - speed_ff;
      torque_dev = (torque_ff >= nom_torque_ff) ? torque_ff - nom_torque_ff
                                                : nom_torque_ff - torque_ff;

      // 20 per 0.1 K of air deviation, 15 per 0.1 K of process deviation
      temp_penalty = 19'(air_dev) * 19'd20 + 19'(proc_dev) * 19'd15;
      if (temp_penalty >= 19'(mhs_pkg::FULL_SCORE)) begin
         temp_in = '0;
      end else begin
         temp_in = mhs_pkg::FULL_SCORE - temp_penalty[13:0];
      end

      speed_dev_s  = $signed({5'd0, speed_dev});
      torque_dev_s = $signed({7'd0, torque_dev});
      torque_s     = $signed({7'd0, torque_ff});
      wear_s       = $signed({8'd0, wear_ff});

      // step from 10000 to 9000 at a deviation of 200 is intended
      priority if (speed_dev < 13'd200) begin
         speed_wide = 18'sd10000;
      end else if (speed_dev < 13'd500) begin
         speed_wide = 18'sd9400 - 18'sd2 * speed_dev_s;
      end else begin
         speed_wide = 18'sd7500 - speed_dev_s;
      end

      priority if (torque_dev < 11'd50) begin
         torque_wide = 18'sd10000;
      end else if (torque_dev < 11'd150) begin
         torque_wide = 18'sd9750 - 18'sd5 * torque_dev_s;
      end else if (torque_ff > 11'd600) begin
         torque_wide = 18'sd10000 - 18'sd5 * torque_s;
      end else begin
         torque_wide = 18'sd7500;
      end

      priority if (wear_ff < 10'd50) begin
         wear_wide = 18'sd10000;
      end else if (wear_ff < 10'd150) begin
         wear_wide = 18'sd12500 - 18'sd50 * wear_s;
      end else if (wear_ff < 10'd250) begin
         wear_wide = 18'sd15000 - 18'sd50 * wear_s;
      end else begin
         wear_wide = 18'sd5000 - 18'sd10 * wear_s;
      end

      speed_in  = speed_wide[14:0];
      torque_in = torque_wide[14:0];
      wear_in   = wear_wide[14:0];

      total_wide = 22'sd35 * 22'(wear_in)
                 + 22'sd25 * ($signed({8'd0, temp_in}) + 22'(torque_in))
                 + 22'sd15 * 22'(speed_in);
      total_in = total_wide[20:0];

      // critical test first, so it wins when the levels are out of order
      priority if (total_wide < $signed({2'b00, crit_level_ff})) begin
         status_in = mhs_pkg::STATUS_CRITICAL;
      end else if (total_wide < $signed({2'b00, warn_level_ff})) begin
         status_in = mhs_pkg::STATUS_WARNING;
      end else begin
         status_in = mhs_pkg::STATUS_HEALTHY;
      end
   end

   // result register
   logic [13:0]                temp_ff;
   logic signed [14:0]         speed_score_ff;
   logic signed [14:0]         torque_score_ff;
   logic signed [14:0]         wear_score_ff;
   logic signed [20:0]         total_ff;
   mhs_pkg::health_status_type status_ff;

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         temp_ff         <= temp_in;
         speed_score_ff  <= speed_in;
         torque_score_ff <= torque_in;
         wear_score_ff   <= wear_in;
         total_ff        <= total_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_temp_score    = temp_ff;
   assign rsp_speed_score   = speed_score_ff;
   assign rsp_torque_score  = torque_score_ff;
   assign rsp_wear_score    = wear_score_ff;
   assign rsp_health_score  = total_ff;
   assign rsp_health_status = status_ff;

endmodule

// ----- sim/tb.sv -----
module tb;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int ITEMS_PER_SET  = 160;
   localparam int NUM_SETS       = 6;
   localparam int DIRECTED_ROWS  = 23;

   // indexes outside the register map; writes there must be dropped
   localparam logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam mhs_pkg::health_status_type ST_OK   = mhs_pkg::STATUS_HEALTHY;
   localparam mhs_pkg::health_status_type ST_WARN = mhs_pkg::STATUS_WARNING;
   localparam mhs_pkg::health_status_type ST_CRIT = mhs_pkg::STATUS_CRITICAL;

   typedef struct {
      logic [12:0] air;
      logic [12:0] proc;
      logic [12:0] speed;
      logic [10:0] torque;
      logic [9:0]  wear;
   } sample_type;

   typedef struct {
      logic [13:0]                temp_s;
      logic signed [14:0]         speed_s;
      logic signed [14:0]         torque_s;
      logic signed [14:0]         wear_s;
      logic signed [20:0]         health;
      mhs_pkg::health_status_type status;
   } score_type;

   typedef struct {
      int air, proc, speed, torque, wear;
      bit typed;
      int temp_s, speed_s, torque_s, wear_s, health;
      mhs_pkg::health_status_type status;
   } directed_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [12:0]                         req_air_temp = '0;
   logic [12:0]                         req_process_temp = '0;
   logic [12:0]                         req_spindle_speed = '0;
   logic [10:0]                         req_torque_sample = '0;
   logic [9:0]                          req_tool_wear = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [13:0]                         rsp_temp_score;
   logic signed [14:0]                  rsp_speed_score;
   logic signed [14:0]                  rsp_torque_score;
   logic signed [14:0]                  rsp_wear_score;
   logic signed [20:0]                  rsp_health_score;
   logic [1:0]                          rsp_health_status;
   logic                                csr_write_enable = 1'b0;
   logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [mhs_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // scorer's view of the registers
   logic [12:0] nom_air    = mhs_pkg::RESET_NOMINAL_AIR_TEMP;
   logic [12:0] nom_proc   = mhs_pkg::RESET_NOMINAL_PROCESS_TEMP;
   logic [12:0] nom_speed  = mhs_pkg::RESET_NOMINAL_SPEED;
   logic [10:0] nom_torque = mhs_pkg::RESET_NOMINAL_TORQUE;
   logic [19:0] crit_level = mhs_pkg::RESET_CRITICAL_LEVEL;
   logic [19:0] warn_level = mhs_pkg::RESET_WARNING_LEVEL;

   score_type expected_scores [$];
   score_type score_head;
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{2980, 3090, 1500,  400,    0, 1, 10000, 10000, 10000, 10000, 1000000, ST_OK},
      '{8191, 8191, 8191, 2047, 1023, 1,     0,   809,  -235, -5230, -176790, ST_CRIT},
      '{   0,    0,    0,    0,    0, 1,     0,  6000,  7500, 10000,  627500, ST_WARN},
      '{2980, 3090, 1699,  400,   49, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1700,  400,   50, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1999,  400,  149, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 2000,  400,  150, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1300,  400,  249, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1001,  400,  250, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  449,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  450,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  549,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  601,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  600,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500,  250,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3090, 1500, 2047, 1023, 0, 0, 0, 0, 0, 0, ST_OK},
      '{3480, 3090, 1500,  400,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2981, 3091, 1500,  400,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2979, 3089, 1500,  400,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2980, 3757, 1500,  400,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{2830, 2890, 1500,  400,    0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{   0, 8191,    0,    0, 1023, 0, 0, 0, 0, 0, 0, ST_OK},
      '{8191,    0, 8191, 2047,    0, 0, 0, 0, 0, 0, 0, ST_OK}
   };

   machine_health_score i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_air_temp      (req_air_temp),
      .req_process_temp  (req_process_temp),
      .req_spindle_speed (req_spindle_speed),
      .req_torque_sample (req_torque_sample),
      .req_tool_wear     (req_tool_wear),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_temp_score    (rsp_temp_score),
      .rsp_speed_score   (rsp_speed_score),
      .rsp_torque_score  (rsp_torque_score),
      .rsp_wear_score    (rsp_wear_score),
      .rsp_health_score  (rsp_health_score),
      .rsp_health_status (rsp_health_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic score_type score_sample(input sample_type s);
      int        dev;
      int        temp_v, speed_v, torque_v, wear_v, total;
      score_type r;
      temp_v = int'(mhs_pkg::FULL_SCORE) - 20 * abs_diff(int'(s.air), int'(nom_air))
               - 15 * abs_diff(int'(s.proc), int'(nom_proc));
      if (temp_v < 0) temp_v = 0;

      dev = abs_diff(int'(s.speed), int'(nom_speed));
      if (dev < 200) speed_v = 10000;
      else if (dev < 500) speed_v = 9000 - 2 * (dev - 200);
      else speed_v = 7000 - (dev - 500);

      dev = abs_diff(int'(s.torque), int'(nom_torque));
      if (dev < 50) torque_v = 10000;
      else if (dev < 150) torque_v = 9500 - 5 * (dev - 50);
      else if (s.torque > 11'd600) torque_v = 7000 - 5 * (int'(s.torque) - 600);
      else torque_v = 7500;

      if (s.wear < 10'd50) wear_v = 10000;
      else if (s.wear < 10'd150) wear_v = 10000 - 50 * (int'(s.wear) - 50);
      else if (s.wear < 10'd250) wear_v = 7500 - 50 * (int'(s.wear) - 150);
      else wear_v = 2500 - 10 * (int'(s.wear) - 250);

      total = 35 * wear_v + 25 * temp_v + 25 * torque_v + 15 * speed_v;

      r.temp_s   = temp_v[13:0];
      r.speed_s  = speed_v[14:0];
      r.torque_s = torque_v[14:0];
      r.wear_s   = wear_v[14:0];
      r.health   = total[20:0];
      // critical is tested first, so it wins when the levels are out of order
      if (total < int'(crit_level)) r.status = mhs_pkg::STATUS_CRITICAL;
      else if (total < int'(warn_level)) r.status = mhs_pkg::STATUS_WARNING;
      else r.status = mhs_pkg::STATUS_HEALTHY;
      return r;
   endfunction

   function automatic int near_value(input int nominal, input int spread, input int max_v);
      int v;
      if ($urandom_range(3) == 0) return int'($urandom_range(max_v));
      v = nominal + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > max_v) v = max_v;
      return v;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.air    = 13'(near_value(int'(nom_air), 400, 8191));
      s.proc   = 13'(near_value(int'(nom_proc), 400, 8191));
      s.speed  = 13'(near_value(int'(nom_speed), 700, 8191));
      s.torque = 11'(near_value(int'(nom_torque), 250, 2047));
      s.wear   = 10'(near_value(150, 150, 1023));
      return s;
   endfunction

   task automatic check_field(input string name, input int want, input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            $error("result transfer with no sample outstanding");
            mismatch_count++;
         end else begin
            score_head = expected_scores.pop_front();
            check_field("temp_score", int'(score_head.temp_s), {18'd0, rsp_temp_score});
            check_field("speed_score", int'(score_head.speed_s), 32'(rsp_speed_score));
            check_field("torque_score", int'(score_head.torque_s), 32'(rsp_torque_score));
            check_field("wear_score", int'(score_head.wear_s), 32'(rsp_wear_score));
            check_field("health_score", int'(score_head.health), 32'(rsp_health_score));
            check_field("health_status", int'(score_head.status), {30'd0, rsp_health_status});
         end
      end
   end

   // valid stays high across back-to-back transfers; it only drops on a gap
   task automatic send_sample(input sample_type s, input bit typed,
                              input score_type typed_scores);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_air_temp      <= s.air;
      req_process_temp  <= s.proc;
      req_spindle_speed <= s.speed;
      req_torque_sample <= s.torque;
      req_tool_wear     <= s.wear;
      do @(posedge clock); while (req_stall);
      expected_scores.push_back(typed ? typed_scores : score_sample(s));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(negedge clock);
      @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [19:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(posedge clock);
      case (idx)
         mhs_pkg::CSR_NOMINAL_AIR_TEMP:     nom_air    = value[12:0];
         mhs_pkg::CSR_NOMINAL_PROCESS_TEMP: nom_proc   = value[12:0];
         mhs_pkg::CSR_NOMINAL_SPEED:        nom_speed  = value[12:0];
         mhs_pkg::CSR_NOMINAL_TORQUE:       nom_torque = value[10:0];
         mhs_pkg::CSR_CRITICAL_LEVEL:       crit_level = value;
         mhs_pkg::CSR_WARNING_LEVEL:        warn_level = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [19:0] air, input logic [19:0] proc,
                               input logic [19:0] spd, input logic [19:0] trq,
                               input logic [19:0] crit, input logic [19:0] warn);
      write_reg(mhs_pkg::CSR_NOMINAL_AIR_TEMP, air);
      write_reg(mhs_pkg::CSR_NOMINAL_PROCESS_TEMP, proc);
      write_reg(mhs_pkg::CSR_NOMINAL_SPEED, spd);
      write_reg(mhs_pkg::CSR_NOMINAL_TORQUE, trq);
      write_reg(mhs_pkg::CSR_CRITICAL_LEVEL, crit);
      write_reg(mhs_pkg::CSR_WARNING_LEVEL, warn);
      write_reg(CSR_UNMAPPED_LO, 20'hFFFFF);
      write_reg(CSR_UNMAPPED_HI, 20'hFFFFF);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      directed_row_type row;
      sample_type       smp;
      score_type        typed_scores;
      int               lo_level, hi_level, tmp;

      send_idle_pct = 35;
      recv_idle_pct = 81;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values are exercised here, nothing written yet
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         smp.air    = 13'(row.air);
         smp.proc   = 13'(row.proc);
         smp.speed  = 13'(row.speed);
         smp.torque = 11'(row.torque);
         smp.wear   = 10'(row.wear);
         typed_scores.temp_s   = 14'(row.temp_s);
         typed_scores.speed_s  = 15'(row.speed_s);
         typed_scores.torque_s = 15'(row.torque_s);
         typed_scores.wear_s   = 15'(row.wear_s);
         typed_scores.health   = 21'(row.health);
         typed_scores.status   = row.status;
         send_sample(smp, row.typed, typed_scores);
      end

      for (int cfg_sel = 0; cfg_sel < NUM_SETS; cfg_sel++) begin
         drain_results();
         case (cfg_sel)
            0: apply_config(20'(mhs_pkg::RESET_NOMINAL_AIR_TEMP),
                            20'(mhs_pkg::RESET_NOMINAL_PROCESS_TEMP),
                            20'(mhs_pkg::RESET_NOMINAL_SPEED),
                            20'(mhs_pkg::RESET_NOMINAL_TORQUE),
                            mhs_pkg::RESET_CRITICAL_LEVEL, mhs_pkg::RESET_WARNING_LEVEL);
            // upper bits set above each nominal width; levels out of order
            1: apply_config(20'hFE000, 20'hFE000, 20'hFE000, 20'hFF800, 20'd900000, 20'd100000);
            2: apply_config(20'd8191, 20'd8191, 20'd8191, 20'd2047, 20'hFFFFF, 20'hFFFFF);
            3: apply_config(20'($urandom_range(8191)), 20'($urandom_range(8191)),
                            20'($urandom_range(8191)), 20'($urandom_range(2047)),
                            20'd0, 20'd0);
            4: begin
               lo_level = $urandom_range(1000000);
               hi_level = $urandom_range(1000000);
               if (lo_level > hi_level) begin
                  tmp = lo_level;
                  lo_level = hi_level;
                  hi_level = tmp;
               end
               apply_config(20'($urandom_range(8191)), 20'($urandom_range(8191)),
                            20'($urandom_range(8191)), 20'($urandom_range(2047)),
                            20'(lo_level), 20'(hi_level));
            end
            default: apply_config(20'($urandom), 20'($urandom), 20'($urandom),
                                  20'($urandom), 20'($urandom), 20'($urandom));
         endcase
         if (cfg_sel < 2) begin
            send_idle_pct = 35;
            recv_idle_pct = 81;
         end else if (cfg_sel < 4) begin
            send_idle_pct = 81;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if (cfg_sel == 1 && n == ITEMS_PER_SET / 2) drain_results();
            send_sample(random_sample(), 1'b0, typed_scores);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
